@@ rtl/lcdseq_pkg.sv @@
// Shared types, codes and constants for the character LCD nibble sequencer.
`default_nettype none

package lcdseq_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE_CHAR = 2'd0,
    KIND_SET_POS    = 2'd1,
    KIND_SET_FLAG   = 2'd2,
    KIND_INIT       = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FUNCTION_SET = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_INIT = 2'd1;
  localparam logic [1:0] CFG_LINE2_START  = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] FUNCTION_SET_RST = 8'd8;
  localparam logic [2:0] DISPLAY_INIT_RST = 3'd4;
  localparam logic [6:0] LINE2_START_RST  = 7'd64;

  // Special characters.
  localparam logic [7:0] CHAR_FORM_FEED = 8'h0C;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_LF        = 8'h0A;

  // Command bytes.
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
  localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h08;
  localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;

  // Flag select code with no matching flag.
  localparam logic [1:0] FLAG_NONE = 2'd3;

  // Init wake-up nibbles.
  localparam logic [3:0] NIB_WAKE    = 4'h3;
  localparam logic [3:0] NIB_4BIT    = 4'h2;

  // Wait times in milliseconds.
  localparam logic [3:0] WAIT_NONE     = 4'd0;
  localparam logic [3:0] WAIT_SETTLE   = 4'd1;
  localparam logic [3:0] WAIT_CLEAR    = 4'd5;
  localparam logic [3:0] WAIT_WAKE     = 4'd5;
  localparam logic [3:0] WAIT_POWER_UP = 4'd15;

  // Transfer step numbering.
  localparam logic [3:0] STEP_WAKE_LAST = 4'd3;
  localparam logic [3:0] STEP_INIT_LAST = 4'd11;
  localparam logic [3:0] STEP_BYTE_LAST = 4'd1;
  localparam logic [2:0] INIT_BYTE_FSET = 3'd2;
  localparam logic [2:0] INIT_BYTE_DCTL = 3'd3;
  localparam logic [2:0] INIT_BYTE_CLR  = 3'd4;

  localparam int QUEUE_DEPTH_DEF = 2;

  // One classified command waiting for the back end.
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte0;      // Single byte, or function-set byte of init.
    logic [7:0] byte1;      // Display-control byte of init.
    logic [3:0] wait_last;  // Wait after the final transfer of a single byte.
  } job_t;

endpackage

`default_nettype wire

@@ rtl/lcdseq_front.sv @@
// Front end: configuration registers, display-control state and command classification.
`default_nettype none

module lcdseq_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_wdata,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_kind,
  input  wire logic [7:0]          in_char_code,
  input  wire logic [6:0]          in_column,
  input  wire logic                in_row,
  input  wire logic [1:0]          in_flag_select,
  input  wire logic                in_flag_value,
  input  wire logic                q_full,
  output      logic                push,
  output      lcdseq_pkg::job_t    push_job
);

  logic [7:0] fset_r;
  logic [2:0] dinit_r;
  logic [6:0] line2_r;
  logic [2:0] dctl_r;
  logic [2:0] dctl_nxt;
  logic [2:0] flag_bits;
  logic [2:0] flag_mask;
  logic [7:0] pos_sum;
  logic [7:0] nl_sum;

  assign push = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fset_r  <= lcdseq_pkg::FUNCTION_SET_RST;
      dinit_r <= lcdseq_pkg::DISPLAY_INIT_RST;
      line2_r <= lcdseq_pkg::LINE2_START_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcdseq_pkg::CFG_FUNCTION_SET: fset_r  <= cfg_wdata;
        lcdseq_pkg::CFG_DISPLAY_INIT: dinit_r <= cfg_wdata[2:0];
        lcdseq_pkg::CFG_LINE2_START:  line2_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dctl_r <= 3'd0;
    end else begin
      dctl_r <= dctl_nxt;
    end
  end

  always_comb begin
    flag_mask = 3'b001 << in_flag_select;
    flag_bits = dctl_r;
    if (in_flag_select != lcdseq_pkg::FLAG_NONE) begin
      flag_bits = in_flag_value ? (dctl_r | flag_mask) : (dctl_r & ~flag_mask);
    end
    pos_sum = {1'b0, (in_row ? line2_r : 7'd0)} + {1'b0, in_column};
    nl_sum  = {1'b0, line2_r} + 8'd1;
  end

  always_comb begin
    dctl_nxt           = dctl_r;
    push_job.is_init   = 1'b0;
    push_job.rs        = 1'b0;
    push_job.byte0     = in_char_code;
    push_job.byte1     = lcdseq_pkg::CMD_DISPLAY_CTRL | {5'd0, dinit_r};
    push_job.wait_last = lcdseq_pkg::WAIT_NONE;
    unique case (lcdseq_pkg::kind_t'(in_kind))
      lcdseq_pkg::KIND_WRITE_CHAR: begin
        priority if (in_char_code == lcdseq_pkg::CHAR_FORM_FEED) begin
          push_job.byte0     = lcdseq_pkg::CMD_CLEAR;
          push_job.wait_last = lcdseq_pkg::WAIT_CLEAR;
        end else if (in_char_code == lcdseq_pkg::CHAR_CR ||
                     in_char_code == lcdseq_pkg::CHAR_LF) begin
          push_job.byte0 = lcdseq_pkg::CMD_SET_ADDR | {1'b0, nl_sum[6:0]};
        end else begin
          push_job.rs = 1'b1;
        end
      end
      lcdseq_pkg::KIND_SET_POS: begin
        push_job.byte0 = lcdseq_pkg::CMD_SET_ADDR | {1'b0, pos_sum[6:0]};
      end
      lcdseq_pkg::KIND_SET_FLAG: begin
        push_job.byte0 = lcdseq_pkg::CMD_DISPLAY_CTRL | {5'd0, flag_bits};
        if (push) begin
          dctl_nxt = flag_bits;
        end
      end
      lcdseq_pkg::KIND_INIT: begin
        push_job.is_init = 1'b1;
        push_job.byte0   = lcdseq_pkg::CMD_FUNCTION_SET | fset_r;
        if (push) begin
          dctl_nxt = dinit_r;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/lcdseq_queue.sv @@
// Short queue of classified commands between the front and back ends.
`default_nettype none

module lcdseq_queue #(
  parameter int DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lcdseq_pkg::job_t push_job,
  input  wire logic             pop,
  output      logic             full,
  output      logic             q_valid,
  output      lcdseq_pkg::job_t q_job
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  lcdseq_pkg::job_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lcdseq_back.sv @@
// Back end: steps through the transfers of one command into an output register.
`default_nettype none

module lcdseq_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire lcdseq_pkg::job_t q_job,
  output      logic             pop,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic             out_register_select,
  output      logic [3:0]       out_nibble,
  output      logic [3:0]       out_wait_before_ms,
  output      logic [3:0]       out_wait_after_ms,
  output      logic             out_last
);

  lcdseq_pkg::job_t job_r, job_nxt;
  logic       active_r, active_nxt;
  logic [3:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       advance;

  logic       x_rs;
  logic [3:0] x_nib, x_wb, x_wa;
  logic       x_last;
  logic [7:0] cur_byte;
  logic [2:0] byte_idx;
  logic       high_half;

  assign out_valid = out_valid_r;
  assign advance   = active_r && (!out_valid_r || !out_stall);
  assign pop       = q_valid && (!active_r || (advance && x_last));

  // Fields of the transfer at the current step.
  always_comb begin
    byte_idx  = step_r[3:1];
    high_half = !step_r[0];
    priority if (!job_r.is_init || byte_idx == lcdseq_pkg::INIT_BYTE_FSET) begin
      cur_byte = job_r.byte0;
    end else if (byte_idx == lcdseq_pkg::INIT_BYTE_DCTL) begin
      cur_byte = job_r.byte1;
    end else if (byte_idx == lcdseq_pkg::INIT_BYTE_CLR) begin
      cur_byte = lcdseq_pkg::CMD_CLEAR;
    end else begin
      cur_byte = lcdseq_pkg::CMD_ENTRY_MODE;
    end
    x_rs   = job_r.rs;
    x_last = job_r.is_init ? (step_r == lcdseq_pkg::STEP_INIT_LAST)
                           : (step_r == lcdseq_pkg::STEP_BYTE_LAST);
    if (job_r.is_init && step_r <= lcdseq_pkg::STEP_WAKE_LAST) begin
      x_nib = (step_r == lcdseq_pkg::STEP_WAKE_LAST) ? lcdseq_pkg::NIB_4BIT
                                                     : lcdseq_pkg::NIB_WAKE;
      x_wb  = (step_r == 4'd0) ? lcdseq_pkg::WAIT_POWER_UP : lcdseq_pkg::WAIT_NONE;
      x_wa  = (step_r == lcdseq_pkg::STEP_WAKE_LAST) ? lcdseq_pkg::WAIT_NONE
                                                     : lcdseq_pkg::WAIT_WAKE;
    end else begin
      x_nib = high_half ? cur_byte[7:4] : cur_byte[3:0];
      x_wb  = high_half ? lcdseq_pkg::WAIT_SETTLE : lcdseq_pkg::WAIT_NONE;
      x_wa  = (x_last && !job_r.is_init) ? job_r.wait_last : lcdseq_pkg::WAIT_NONE;
    end
  end

  always_comb begin
    job_nxt       = job_r;
    active_nxt    = active_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      step_nxt      = step_r + 4'd1;
      if (x_last) begin
        active_nxt = 1'b0;
      end
    end
    if (pop) begin
      job_nxt    = q_job;
      active_nxt = 1'b1;
      step_nxt   = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      step_r      <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    if (advance) begin
      out_register_select <= x_rs;
      out_nibble          <= x_nib;
      out_wait_before_ms  <= x_wb;
      out_wait_after_ms   <= x_wa;
      out_last            <= x_last;
    end
  end

  a_byte_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && !job_r.is_init) |-> (step_r <= lcdseq_pkg::STEP_BYTE_LAST))
    else $error("single-byte command ran past its second transfer");

  a_power_up_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && job_r.is_init && step_r == 4'd0) |=>
      (out_wait_before_ms == lcdseq_pkg::WAIT_POWER_UP))
    else $error("init did not open with the power-up wait");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("back end took a command from an empty queue");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && x_last && !pop) |=> !active_r)
    else $error("command stayed active after its final transfer");

endmodule

`default_nettype wire

@@ rtl/char_lcd_nibble_sequencer.sv @@
// Top level of the character LCD nibble sequencer: front end, command queue and back end.
// Path: an accepted command goes through a queue slot and the job register to the output register.
// Throughput: one transfer per cycle from the back end's step counter unless out_stall holds it;
// two for a byte command, twelve for init, and each command follows the last without a gap.
// The queue holds QUEUE_DEPTH classified commands (default two); input stalls only when it is full.
// Reset: rst_n is synchronous and active low; it restores the register defaults and clears
// the display-control bits, the queue and the output valid flag.
`default_nettype none

module char_lcd_nibble_sequencer #(
  parameter int QUEUE_DEPTH = lcdseq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration write port.
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  // Command channel.
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic [1:0] in_kind,
  input  wire logic [7:0] in_char_code,
  input  wire logic [6:0] in_column,
  input  wire logic       in_row,
  input  wire logic [1:0] in_flag_select,
  input  wire logic       in_flag_value,
  // Transfer channel.
  output      logic       out_valid,
  input  wire logic       out_stall,
  output      logic       out_register_select,
  output      logic [3:0] out_nibble,
  output      logic [3:0] out_wait_before_ms,
  output      logic [3:0] out_wait_after_ms,
  output      logic       out_last
);

  // The front end classifies each command as it is accepted: it resolves the special
  // characters, computes the display address and updates the display-control bits in
  // command order, so that every queued entry carries its final byte values.
  logic             q_full;
  logic             push;
  lcdseq_pkg::job_t push_job;

  // The back end pops one entry at a time and walks its transfers, loading the next
  // entry in the same cycle that the previous one issues its final transfer.
  logic             pop;
  logic             q_valid;
  lcdseq_pkg::job_t q_job;

  assign in_stall = q_full;

  lcdseq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_kind        (in_kind),
    .in_char_code   (in_char_code),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_flag_select (in_flag_select),
    .in_flag_value  (in_flag_value),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  lcdseq_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  // The output register holds a transfer while it is stalled; the back end refills it in
  // the same cycle that the sink takes it.
  lcdseq_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_job               (q_job),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_wait_before_ms  (out_wait_before_ms),
    .out_wait_after_ms   (out_wait_after_ms),
    .out_last            (out_last)
  );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the character LCD nibble sequencer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous bound on the whole run. The slowest legal run is roughly 450 commands,
  // each with the longest idle gap and twelve transfers that each see the longest
  // receiver stall, which stays well under CYCLE_LIMIT.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_MAX     = 13;
  // Cycles allowed after the last expected transfer before the block counts as idle.
  localparam int DRAIN_CYCLES = 8;

  // One bus transfer as it appears on the result channel.
  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic [3:0] wait_before;
    logic [3:0] wait_after;
    logic       last;
  } xfer_t;

  // One command as it is driven on the input channel.
  typedef struct packed {
    lcdseq_pkg::kind_t kind;
    logic [7:0]        char_code;
    logic [6:0]        column;
    logic              row;
    logic [1:0]        flag_select;
    logic              flag_value;
  } lcd_cmd_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_kind = '0;
  logic [7:0] in_char_code = '0;
  logic [6:0] in_column = '0;
  logic       in_row = 1'b0;
  logic [1:0] in_flag_select = '0;
  logic       in_flag_value = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_register_select;
  logic [3:0] out_nibble;
  logic [3:0] out_wait_before_ms;
  logic [3:0] out_wait_after_ms;
  logic       out_last;

  // Transfers the block still owes us, oldest first.
  xfer_t      pending_xfers[$];

  // Our own copy of the configuration registers and the display-control bits.
  logic [7:0] fset_flags  = lcdseq_pkg::FUNCTION_SET_RST;
  logic [2:0] disp_init   = lcdseq_pkg::DISPLAY_INIT_RST;
  logic [6:0] line2_start = lcdseq_pkg::LINE2_START_RST;
  logic [2:0] dctl_bits   = '0;

  bit          failed = 1'b0;
  bit          steady = 1'b0;  // When set, neither side idles or stalls.
  int unsigned cycles = 0;
  int unsigned stall_left = 0;

  char_lcd_nibble_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_char_code        (in_char_code),
    .in_column           (in_column),
    .in_row              (in_row),
    .in_flag_select      (in_flag_select),
    .in_flag_value       (in_flag_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_register_select (out_register_select),
    .out_nibble          (out_nibble),
    .out_wait_before_ms  (out_wait_before_ms),
    .out_wait_after_ms   (out_wait_after_ms),
    .out_last            (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The run is cut off if it hangs anywhere.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Number of cycles one side holds off before its next transfer.
  function automatic int unsigned draw_idle();
    return steady ? 0 : $urandom_range(0, IDLE_MAX);
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer predictor
  // ---------------------------------------------------------------------------

  task automatic push_xfer(input logic rs, input logic [3:0] nib, input logic [3:0] wb,
                           input logic [3:0] wa, input logic fin);
    xfer_t x;
    x = '{rs: rs, nibble: nib, wait_before: wb, wait_after: wa, last: fin};
    pending_xfers.push_back(x);
  endtask

  // A byte goes out high nibble first; the high nibble always carries the settle
  // wait in front of it, and the low nibble may carry a wait after it.
  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [3:0] wa_low,
                           input logic fin);
    push_xfer(rs, b[7:4], lcdseq_pkg::WAIT_SETTLE, lcdseq_pkg::WAIT_NONE, 1'b0);
    push_xfer(rs, b[3:0], lcdseq_pkg::WAIT_NONE, wa_low, fin);
  endtask

  // Works out every transfer that one accepted command causes, in order, and
  // updates the display-control bits the same way the block must.
  task automatic predict_transfers(input lcd_cmd_t c);
    logic [6:0] addr;
    case (c.kind)
      lcdseq_pkg::KIND_WRITE_CHAR: begin
        if (c.char_code == lcdseq_pkg::CHAR_FORM_FEED) begin
          // Clear needs a long wait after its final nibble.
          push_byte(1'b0, lcdseq_pkg::CMD_CLEAR, lcdseq_pkg::WAIT_CLEAR, 1'b1);
        end else if (c.char_code == lcdseq_pkg::CHAR_CR ||
                     c.char_code == lcdseq_pkg::CHAR_LF) begin
          // Both line breaks land on column 1 of the second line.
          addr = line2_start + 7'd1;
          push_byte(1'b0, lcdseq_pkg::CMD_SET_ADDR | {1'b0, addr},
                    lcdseq_pkg::WAIT_NONE, 1'b1);
        end else begin
          push_byte(1'b1, c.char_code, lcdseq_pkg::WAIT_NONE, 1'b1);
        end
      end
      lcdseq_pkg::KIND_SET_POS: begin
        // The address wraps at 128 through the 7-bit sum.
        addr = (c.row ? line2_start : 7'd0) + c.column;
        push_byte(1'b0, lcdseq_pkg::CMD_SET_ADDR | {1'b0, addr},
                  lcdseq_pkg::WAIT_NONE, 1'b1);
      end
      lcdseq_pkg::KIND_SET_FLAG: begin
        // The select code with no flag behind it still resends display-control.
        if (c.flag_select != lcdseq_pkg::FLAG_NONE) dctl_bits[c.flag_select] = c.flag_value;
        push_byte(1'b0, lcdseq_pkg::CMD_DISPLAY_CTRL | {5'd0, dctl_bits},
                  lcdseq_pkg::WAIT_NONE, 1'b1);
      end
      default: begin
        // Wake-up sequence, switch to the 4-bit bus, then the four setup bytes.
        push_xfer(1'b0, lcdseq_pkg::NIB_WAKE, lcdseq_pkg::WAIT_POWER_UP,
                  lcdseq_pkg::WAIT_WAKE, 1'b0);
        push_xfer(1'b0, lcdseq_pkg::NIB_WAKE, lcdseq_pkg::WAIT_NONE,
                  lcdseq_pkg::WAIT_WAKE, 1'b0);
        push_xfer(1'b0, lcdseq_pkg::NIB_WAKE, lcdseq_pkg::WAIT_NONE,
                  lcdseq_pkg::WAIT_WAKE, 1'b0);
        push_xfer(1'b0, lcdseq_pkg::NIB_4BIT, lcdseq_pkg::WAIT_NONE,
                  lcdseq_pkg::WAIT_NONE, 1'b0);
        push_byte(1'b0, lcdseq_pkg::CMD_FUNCTION_SET | fset_flags,
                  lcdseq_pkg::WAIT_NONE, 1'b0);
        dctl_bits = disp_init;
        push_byte(1'b0, lcdseq_pkg::CMD_DISPLAY_CTRL | {5'd0, dctl_bits},
                  lcdseq_pkg::WAIT_NONE, 1'b0);
        push_byte(1'b0, lcdseq_pkg::CMD_CLEAR, lcdseq_pkg::WAIT_NONE, 1'b0);
        push_byte(1'b0, lcdseq_pkg::CMD_ENTRY_MODE, lcdseq_pkg::WAIT_NONE, 1'b1);
      end
    endcase
  endtask

  // Every command transfer accepted at this edge is predicted right away, so the
  // display-control bits follow the same order as the block's own updates.
  always @(posedge clk) begin
    if (!rst_n) begin
      dctl_bits = '0;
    end else if (in_valid && !in_stall) begin
      predict_transfers('{kind: lcdseq_pkg::kind_t'(in_kind), char_code: in_char_code,
                          column: in_column, row: in_row,
                          flag_select: in_flag_select, flag_value: in_flag_value});
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and receiver stalls
  // ---------------------------------------------------------------------------

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Each accepted transfer is matched field by field against the oldest one owed.
  // After each transfer the receiver draws how long it stalls before the next one.
  always @(posedge clk) begin : check_xfers
    xfer_t got;
    xfer_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{rs: out_register_select, nibble: out_nibble, wait_before: out_wait_before_ms,
              wait_after: out_wait_after_ms, last: out_last};
      if (pending_xfers.size() == 0) begin
        $display("%0t ns: unexpected transfer, expected none, actual rs=%0d nibble=%0d last=%0d",
                 $time, got.rs, got.nibble, got.last);
        failed = 1'b1;
      end else begin
        want = pending_xfers.pop_front();
        report_field("register_select", want.rs, got.rs);
        report_field("nibble", want.nibble, got.nibble);
        report_field("wait_before_ms", want.wait_before, got.wait_before);
        report_field("wait_after_ms", want.wait_after, got.wait_after);
        report_field("last", want.last, got.last);
      end
      stall_left = draw_idle();
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall <= rst_n && (stall_left != 0);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one command: an optional hold-off with valid low, then valid stays high
  // until the block takes the transfer. Valid is left high on return, so a
  // back-to-back command simply replaces the payload at the accepting edge.
  task automatic send_cmd(input lcd_cmd_t c);
    int unsigned gap;
    gap = draw_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= c.kind;
    in_char_code   <= c.char_code;
    in_column      <= c.column;
    in_row         <= c.row;
    in_flag_select <= c.flag_select;
    in_flag_value  <= c.flag_value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Fields that a command does not use are filled at random.
  function automatic lcd_cmd_t any_cmd(input lcdseq_pkg::kind_t kind);
    lcd_cmd_t c;
    c.kind        = kind;
    c.char_code   = 8'($urandom);
    c.column      = 7'($urandom);
    c.row         = 1'($urandom);
    c.flag_select = 2'($urandom);
    c.flag_value  = 1'($urandom);
    return c;
  endfunction

  task automatic send_char(input logic [7:0] ch);
    lcd_cmd_t c;
    c = any_cmd(lcdseq_pkg::KIND_WRITE_CHAR);
    c.char_code = ch;
    send_cmd(c);
  endtask

  task automatic send_pos(input logic row, input logic [6:0] col);
    lcd_cmd_t c;
    c = any_cmd(lcdseq_pkg::KIND_SET_POS);
    c.row = row;
    c.column = col;
    send_cmd(c);
  endtask

  task automatic send_flag(input logic [1:0] sel, input logic val);
    lcd_cmd_t c;
    c = any_cmd(lcdseq_pkg::KIND_SET_FLAG);
    c.flag_select = sel;
    c.flag_value = val;
    send_cmd(c);
  endtask

  // Drops valid and holds the sender back until every owed transfer has come,
  // plus a few cycles so the back end has fully wound down. The first edge lets
  // the predictor record a command accepted at the edge the caller stopped on.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_xfers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    case (index)
      lcdseq_pkg::CFG_FUNCTION_SET: fset_flags = data;
      lcdseq_pkg::CFG_DISPLAY_INIT: disp_init = data[2:0];
      lcdseq_pkg::CFG_LINE2_START:  line2_start = data[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_config(input logic [7:0] fset, input logic [7:0] dinit,
                              input logic [7:0] l2start);
    write_reg(lcdseq_pkg::CFG_FUNCTION_SET, fset);
    write_reg(lcdseq_pkg::CFG_DISPLAY_INIT, dinit);
    write_reg(lcdseq_pkg::CFG_LINE2_START, l2start);
  endtask

  // Min, max or any byte; the narrower registers keep only their low bits.
  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Runs with the reset configuration: the reset state of the display-control
  // bits, init, every character class including the boundary neighbors of the
  // special characters, position extremes with wrap, and every flag change.
  task automatic test_directed_commands();
    send_flag(lcdseq_pkg::FLAG_NONE, 1'b1);
    send_cmd(any_cmd(lcdseq_pkg::KIND_INIT));
    send_char(8'h00);
    send_char(8'hFF);
    send_char(lcdseq_pkg::CHAR_FORM_FEED);
    send_char(lcdseq_pkg::CHAR_CR);
    send_char(lcdseq_pkg::CHAR_LF);
    send_char(8'h41);
    send_char(8'h09);
    send_char(8'h0B);
    send_char(8'h0E);
    send_pos(1'b0, 7'd0);
    send_pos(1'b0, 7'd127);
    send_pos(1'b1, 7'd0);
    send_pos(1'b1, 7'd127);
    send_flag(2'd0, 1'b1);
    send_flag(2'd1, 1'b1);
    send_flag(2'd2, 1'b0);
    send_flag(2'd2, 1'b1);
    send_flag(2'd0, 1'b0);
    send_flag(2'd1, 1'b0);
    send_flag(lcdseq_pkg::FLAG_NONE, 1'b0);
  endtask

  // All registers at their top, then all at zero. The line-two start at 127 makes
  // a line break wrap to address 0.
  task automatic test_config_extremes();
    wait_idle();
    write_config(8'hFF, 8'hFF, 8'hFF);
    send_cmd(any_cmd(lcdseq_pkg::KIND_INIT));
    send_char(lcdseq_pkg::CHAR_CR);
    send_pos(1'b1, 7'd1);
    send_pos(1'b1, 7'd127);
    send_flag(2'd1, 1'b0);
    wait_idle();
    write_config(8'h00, 8'h00, 8'h00);
    send_cmd(any_cmd(lcdseq_pkg::KIND_INIT));
    send_char(lcdseq_pkg::CHAR_LF);
    send_pos(1'b1, 7'd127);
    send_flag(2'd2, 1'b1);
  endtask

  // One phase of random traffic under a fresh random configuration. Init is kept
  // rarer since it is six times as long, and line breaks and form feed are mixed
  // in far more often than a uniform byte would give them.
  task automatic test_random_traffic(input int unsigned count, input bit no_idle);
    lcd_cmd_t c;
    wait_idle();
    write_config(pick_reg_value(), pick_reg_value(), pick_reg_value());
    steady = no_idle;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0, 1, 2: c = any_cmd(lcdseq_pkg::KIND_WRITE_CHAR);
        3, 4:    c = any_cmd(lcdseq_pkg::KIND_SET_POS);
        5, 6:    c = any_cmd(lcdseq_pkg::KIND_SET_FLAG);
        default: c = any_cmd(lcdseq_pkg::KIND_INIT);
      endcase
      if (c.kind == lcdseq_pkg::KIND_WRITE_CHAR && $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0:       c.char_code = lcdseq_pkg::CHAR_FORM_FEED;
          1:       c.char_code = lcdseq_pkg::CHAR_CR;
          default: c.char_code = lcdseq_pkg::CHAR_LF;
        endcase
      end
      send_cmd(c);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_commands();
    test_config_extremes();
    for (int phase = 0; phase < 4; phase++) test_random_traffic(95, phase == 2);
    wait_idle();
    if (!failed && pending_xfers.size() == 0) begin
      $display("tb OK");
    end else begin
      if (pending_xfers.size() != 0)
        $display("%0t ns: transfers still owed, expected 0, actual %0d",
                 $time, pending_xfers.size());
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
